/* rtl/chgs_pkg.sv */
// ============================================================================
// chgs_pkg
// Shared constants and types for the Graham-scan convex hull block.
// ============================================================================
package chgs_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 31;
    localparam int FIELD_W    = 31;
    localparam int OID_W      = 11;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DW         = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DW;
    localparam int ACC_W      = PROD_W + 1;
    localparam int PT_W       = 2 * COORD_BITS + IDX_W;

    typedef struct packed {
        logic [IDX_W-1:0]      id;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_point;

    typedef struct packed {
        logic          start;
        logic          sub;
        logic [DW-1:0] a1;
        logic [DW-1:0] b1;
        logic [DW-1:0] a2;
        logic [DW-1:0] b2;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] value;
    } t_alu_rsp;

endpackage

/* rtl/chgs_ram.sv */
// ============================================================================
// chgs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module chgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/chgs_alu.sv */
// ============================================================================
// chgs_alu
// Shared multiply-accumulate unit: a1*b1 +/- a2*b2 on one multiplier.
// ============================================================================
module chgs_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  chgs_pkg::t_alu_req i_req,
    output chgs_pkg::t_alu_rsp o_rsp
);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL1 = 5'b00010,
        A_MUL2 = 5'b00100,
        A_ACC  = 5'b01000,
        A_DONE = 5'b10000
    } t_alu_st;

    t_alu_st r_st, n_st;
    logic                        r_sub;
    logic [chgs_pkg::DW-1:0]     r_a1, r_b1, r_a2, r_b2;
    logic [chgs_pkg::PROD_W-1:0] r_prod;
    logic [chgs_pkg::ACC_W-1:0]  r_acc;
    logic [chgs_pkg::DW-1:0]     m_a, m_b;
    logic signed [chgs_pkg::PROD_W-1:0] mul_p;
    logic signed [chgs_pkg::ACC_W-1:0]  prod_ext;

    assign m_a      = (r_st == A_MUL1) ? r_a1 : r_a2;
    assign m_b      = (r_st == A_MUL1) ? r_b1 : r_b2;
    assign mul_p    = $signed(m_a) * $signed(m_b);
    assign prod_ext = chgs_pkg::ACC_W'($signed(r_prod));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            A_IDLE: if (i_req.start) n_st = A_MUL1;
            A_MUL1: n_st = A_MUL2;
            A_MUL2: n_st = A_ACC;
            A_ACC:  n_st = A_DONE;
            A_DONE: n_st = i_req.start ? A_MUL1 : A_IDLE;
            default: n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_st == A_IDLE || r_st == A_DONE) && i_req.start) begin
            r_sub <= i_req.sub;
            r_a1  <= i_req.a1;
            r_b1  <= i_req.b1;
            r_a2  <= i_req.a2;
            r_b2  <= i_req.b2;
        end
        if (r_st == A_MUL1 || r_st == A_MUL2) begin
            r_prod <= mul_p;
        end
        if (r_st == A_MUL2) begin
            r_acc <= prod_ext;
        end else if (r_st == A_ACC) begin
            r_acc <= r_sub ? ($signed(r_acc) - prod_ext) : ($signed(r_acc) + prod_ext);
        end
    end

    assign o_rsp.done  = (r_st == A_DONE);
    assign o_rsp.value = r_acc;

endmodule

/* rtl/convex_hull_graham_scan.sv */
// ============================================================================
// convex_hull_graham_scan
// Loads points, finds the anchor, insertion-sorts by angle and runs a
// Graham scan over a point RAM and a hull stack RAM with one shared MAC.
// ============================================================================
// Load item: stored if there is room, and the input stays ready. Final load: minimum pass, then
// insertion sort (O(n^2) compares) and scan on the shared MAC and the single
// point RAM read port. Read item: a result from the stack, or an empty one once
// the list has ended, after any points tested in the collinear pass; no new item
// is taken until the result is placed in the output register.
// Synchronous active-low reset clears control state; RAMs are not cleared.
module convex_hull_graham_scan (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [30:0] coord_x, [61:31] coord_y, [63:62] zero
    input  logic [chgs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    // [0] action
    input  logic [0:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [10:0] point_id, [15:11] zero
    output logic [chgs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // [0] list_empty, [1] overflow
    output logic [1:0]                      o_m_axis_tuser
);

    localparam logic ACT_LOAD = 1'b0;
    localparam int   NS       = 41;

    typedef enum logic [NS-1:0] {
        S_IDLE      = NS'(1) << 0,
        S_MIN       = NS'(1) << 1,
        S_SMALL0    = NS'(1) << 2,
        S_SMALL1    = NS'(1) << 3,
        S_SWAP0     = NS'(1) << 4,
        S_SWAP1     = NS'(1) << 5,
        S_INS_RD    = NS'(1) << 6,
        S_INS_T     = NS'(1) << 7,
        S_INS_CHK   = NS'(1) << 8,
        S_INS_P     = NS'(1) << 9,
        S_INS_EQ    = NS'(1) << 10,
        S_INS_CX_GO = NS'(1) << 11,
        S_INS_CX_W  = NS'(1) << 12,
        S_INS_DI_GO = NS'(1) << 13,
        S_INS_DI_W  = NS'(1) << 14,
        S_INS_DJ_GO = NS'(1) << 15,
        S_INS_DJ_W  = NS'(1) << 16,
        S_SCAN_I0   = NS'(1) << 17,
        S_SCAN_I1   = NS'(1) << 18,
        S_SCAN_RD   = NS'(1) << 19,
        S_SCAN_C    = NS'(1) << 20,
        S_SCAN_TST  = NS'(1) << 21,
        S_SCAN_A1   = NS'(1) << 22,
        S_SCAN_A2   = NS'(1) << 23,
        S_SCAN_B    = NS'(1) << 24,
        S_SCAN_X_GO = NS'(1) << 25,
        S_SCAN_X_W  = NS'(1) << 26,
        S_SCAN_D_GO = NS'(1) << 27,
        S_SCAN_D_W  = NS'(1) << 28,
        S_FIN0      = NS'(1) << 29,
        S_FIN1      = NS'(1) << 30,
        S_FIN2      = NS'(1) << 31,
        S_SIDE_TST  = NS'(1) << 32,
        S_SIDE_P    = NS'(1) << 33,
        S_SIDE_EQ   = NS'(1) << 34,
        S_SIDE_X_GO = NS'(1) << 35,
        S_SIDE_X_W  = NS'(1) << 36,
        S_STK_TST   = NS'(1) << 37,
        S_STK_A     = NS'(1) << 38,
        S_STK_B     = NS'(1) << 39,
        S_EMIT      = NS'(1) << 40
    } t_state;

    typedef enum logic [3:0] {
        PH_LOAD  = 4'b0001,
        PH_SIDE  = 4'b0010,
        PH_STACK = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    t_state r_st, n_st;
    t_phase r_phase, n_phase;
    logic [chgs_pkg::CNT_W-1:0] r_count, n_count, r_depth, n_depth;
    logic [chgs_pkg::CNT_W-1:0] r_cursor, n_cursor, r_i, n_i, r_j, n_j;
    logic [chgs_pkg::IDX_W-1:0] r_lo, n_lo, r_pidx, n_pidx;
    logic                       r_ovf, n_ovf, r_pend, n_pend;
    chgs_pkg::t_point r_best, n_best, r_rec0, n_rec0, r_t, n_t;
    chgs_pkg::t_point r_p, n_p, r_bp, n_bp, r_q, n_q;
    logic [chgs_pkg::ACC_W-1:0] r_di, n_di;
    logic [chgs_pkg::OID_W-1:0] r_rid, n_rid, r_oid, n_oid;
    logic r_rlast, n_rlast, r_rempty, n_rempty;
    logic r_ov, n_ov, r_olast, n_olast, r_oempty, n_oempty, r_oovf, n_oovf;

    logic                       pr_we;
    logic [chgs_pkg::IDX_W-1:0] pr_waddr, pr_raddr;
    chgs_pkg::t_point           pr_wdata;
    logic [chgs_pkg::PT_W-1:0]  pr_rdata;
    chgs_pkg::t_point           q_pt;
    logic                       sr_we;
    logic [chgs_pkg::IDX_W-1:0] sr_waddr, sr_raddr, sr_wdata, sr_q;

    chgs_pkg::t_alu_req alu_req;
    chgs_pkg::t_alu_rsp alu_rsp;
    logic alu_neg, alu_zero;
    logic in_fire, out_free;
    logic do_place, do_shift, do_push, do_pop;

    function automatic logic [chgs_pkg::DW-1:0] f_diff(
        logic [chgs_pkg::COORD_BITS-1:0] a, logic [chgs_pkg::COORD_BITS-1:0] b);
        f_diff = chgs_pkg::DW'($signed(a)) - chgs_pkg::DW'($signed(b));
    endfunction

    function automatic chgs_pkg::t_alu_req f_cross(
        chgs_pkg::t_point a, chgs_pkg::t_point b, chgs_pkg::t_point c);
        chgs_pkg::t_alu_req req;
        req.start = 1'b1;
        req.sub   = 1'b1;
        req.a1    = f_diff(b.x, a.x);
        req.b1    = f_diff(c.y, a.y);
        req.a2    = f_diff(b.y, a.y);
        req.b2    = f_diff(c.x, a.x);
        return req;
    endfunction

    function automatic chgs_pkg::t_alu_req f_dot(
        chgs_pkg::t_point a, chgs_pkg::t_point b, chgs_pkg::t_point c);
        chgs_pkg::t_alu_req req;
        req.start = 1'b1;
        req.sub   = 1'b0;
        req.a1    = f_diff(b.x, a.x);
        req.b1    = f_diff(c.x, b.x);
        req.a2    = f_diff(b.y, a.y);
        req.b2    = f_diff(c.y, b.y);
        return req;
    endfunction

    function automatic chgs_pkg::t_alu_req f_dist(chgs_pkg::t_point a, chgs_pkg::t_point p);
        chgs_pkg::t_alu_req req;
        req.start = 1'b1;
        req.sub   = 1'b0;
        req.a1    = f_diff(p.x, a.x);
        req.b1    = f_diff(p.x, a.x);
        req.a2    = f_diff(p.y, a.y);
        req.b2    = f_diff(p.y, a.y);
        return req;
    endfunction

    function automatic logic f_same(chgs_pkg::t_point a, chgs_pkg::t_point b);
        return (a.x == b.x) && (a.y == b.y);
    endfunction

    chgs_ram #(.WIDTH(chgs_pkg::PT_W), .DEPTH(chgs_pkg::MAX_POINTS)) u_pt_ram (
        .i_clk  (i_clk),
        .i_we   (pr_we),
        .i_waddr(pr_waddr),
        .i_wdata(pr_wdata),
        .i_raddr(pr_raddr),
        .o_rdata(pr_rdata)
    );

    chgs_ram #(.WIDTH(chgs_pkg::IDX_W), .DEPTH(chgs_pkg::MAX_POINTS)) u_stk_ram (
        .i_clk  (i_clk),
        .i_we   (sr_we),
        .i_waddr(sr_waddr),
        .i_wdata(sr_wdata),
        .i_raddr(sr_raddr),
        .o_rdata(sr_q)
    );

    chgs_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    assign q_pt     = chgs_pkg::t_point'(pr_rdata);
    assign alu_neg  = alu_rsp.value[chgs_pkg::ACC_W-1];
    assign alu_zero = (alu_rsp.value == '0);
    assign o_s_axis_tready = (r_st == S_IDLE);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;

    always_comb begin
        logic [chgs_pkg::CNT_W-1:0] ec;
        logic [chgs_pkg::CNT_W-1:0] inc_i;
        chgs_pkg::t_point           ld;
        n_st = r_st;  n_phase = r_phase;  n_count = r_count;  n_depth = r_depth;
        n_cursor = r_cursor;  n_i = r_i;  n_j = r_j;  n_lo = r_lo;  n_pidx = r_pidx;
        n_ovf = r_ovf;  n_pend = r_pend;  n_best = r_best;  n_rec0 = r_rec0;
        n_t = r_t;  n_p = r_p;  n_bp = r_bp;  n_q = r_q;  n_di = r_di;
        n_rid = r_rid;  n_rlast = r_rlast;  n_rempty = r_rempty;
        n_ov = r_ov && !i_m_axis_tready;
        n_oid = r_oid;  n_olast = r_olast;  n_oempty = r_oempty;  n_oovf = r_oovf;
        pr_we = 1'b0;  pr_waddr = '0;  pr_wdata = r_t;  pr_raddr = '0;
        sr_we = 1'b0;  sr_waddr = '0;  sr_wdata = '0;  sr_raddr = '0;
        alu_req = '0;
        do_place = 1'b0;  do_shift = 1'b0;  do_push = 1'b0;  do_pop = 1'b0;
        inc_i = r_i + chgs_pkg::CNT_W'(1);
        ec = '0;
        ld.x  = i_s_axis_tdata[chgs_pkg::COORD_BITS-1:0];
        ld.y  = i_s_axis_tdata[chgs_pkg::FIELD_W +: chgs_pkg::COORD_BITS];
        ld.id = '0;

        unique case (r_st)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_s_axis_tuser[0] == ACT_LOAD) begin
                        ec = (r_phase == PH_LOAD) ? r_count : '0;
                        if (r_phase != PH_LOAD) begin
                            n_phase = PH_LOAD;  n_depth = '0;  n_cursor = '0;
                            n_ovf = 1'b0;
                        end
                        if (ec < chgs_pkg::CNT_W'(chgs_pkg::MAX_POINTS)) begin
                            ld.id    = ec[chgs_pkg::IDX_W-1:0];
                            pr_we    = 1'b1;
                            pr_waddr = ec[chgs_pkg::IDX_W-1:0];
                            pr_wdata = ld;
                            n_count  = ec + chgs_pkg::CNT_W'(1);
                        end else begin
                            n_ovf   = 1'b1;
                            n_count = ec;
                        end
                        if (i_s_axis_tlast) begin
                            n_cursor = '0;  n_i = '0;  n_pend = 1'b0;
                            n_st = S_MIN;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_SIDE:  n_st = S_SIDE_TST;
                            PH_STACK: n_st = S_STK_TST;
                            default: begin
                                n_rid = '0;  n_rlast = 1'b0;  n_rempty = 1'b1;
                                n_st = S_EMIT;
                            end
                        endcase
                    end
                end
            end
            S_MIN: begin
                pr_raddr = r_i[chgs_pkg::IDX_W-1:0];
                n_pend   = (r_i < r_count);
                n_pidx   = r_i[chgs_pkg::IDX_W-1:0];
                if (r_i < r_count) n_i = inc_i;
                if (r_pend) begin
                    if (r_pidx == '0) begin
                        n_best = q_pt;  n_rec0 = q_pt;  n_lo = '0;
                    end else if (($signed(q_pt.y) < $signed(r_best.y)) ||
                                 ((q_pt.y == r_best.y) &&
                                  ($signed(q_pt.x) < $signed(r_best.x)))) begin
                        n_best = q_pt;  n_lo = r_pidx;
                    end
                end
                if (!(r_i < r_count) && !r_pend) begin
                    n_st = (r_count < chgs_pkg::CNT_W'(3)) ? S_SMALL0 : S_SWAP0;
                end
            end
            S_SMALL0: begin
                sr_we = 1'b1;  sr_waddr = '0;  sr_wdata = r_lo;
                n_depth  = r_count;
                n_cursor = '0;
                n_phase  = (r_count == '0) ? PH_DONE : PH_STACK;
                n_st = (r_count == chgs_pkg::CNT_W'(2)) ? S_SMALL1 : S_IDLE;
            end
            S_SMALL1: begin
                sr_we    = 1'b1;
                sr_waddr = chgs_pkg::IDX_W'(1);
                sr_wdata = (r_lo == chgs_pkg::IDX_W'(1)) ? '0 : chgs_pkg::IDX_W'(1);
                n_st = S_IDLE;
            end
            S_SWAP0: begin
                pr_we = 1'b1;  pr_waddr = '0;  pr_wdata = r_best;
                n_st = S_SWAP1;
            end
            S_SWAP1: begin
                pr_we = 1'b1;  pr_waddr = r_lo;  pr_wdata = r_rec0;
                n_i = chgs_pkg::CNT_W'(2);
                n_st = S_INS_RD;
            end
            S_INS_RD: begin
                pr_raddr = r_i[chgs_pkg::IDX_W-1:0];
                n_st = S_INS_T;
            end
            S_INS_T: begin
                n_t = q_pt;  n_j = r_i;
                n_st = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (r_j > chgs_pkg::CNT_W'(1)) begin
                    pr_raddr = chgs_pkg::IDX_W'(r_j - chgs_pkg::CNT_W'(1));
                    n_st = S_INS_P;
                end else begin
                    do_place = 1'b1;
                end
            end
            S_INS_P: begin
                n_p = q_pt;
                n_st = S_INS_EQ;
            end
            S_INS_EQ: begin
                if (f_same(r_p, r_best)) do_place = 1'b1;
                else if (f_same(r_t, r_best)) do_shift = 1'b1;
                else n_st = S_INS_CX_GO;
            end
            S_INS_CX_GO: begin
                alu_req = f_cross(r_best, r_t, r_p);
                n_st = S_INS_CX_W;
            end
            S_INS_CX_W: begin
                if (alu_rsp.done) begin
                    if (alu_zero) n_st = S_INS_DI_GO;
                    else if (!alu_neg) do_shift = 1'b1;
                    else do_place = 1'b1;
                end
            end
            S_INS_DI_GO: begin
                alu_req = f_dist(r_best, r_t);
                n_st = S_INS_DI_W;
            end
            S_INS_DI_W: begin
                if (alu_rsp.done) begin
                    n_di = alu_rsp.value;
                    n_st = S_INS_DJ_GO;
                end
            end
            S_INS_DJ_GO: begin
                alu_req = f_dist(r_best, r_p);
                n_st = S_INS_DJ_W;
            end
            S_INS_DJ_W: begin
                if (alu_rsp.done) begin
                    if ($signed(r_di) < $signed(alu_rsp.value)) do_shift = 1'b1;
                    else do_place = 1'b1;
                end
            end
            S_SCAN_I0: begin
                sr_we = 1'b1;  sr_waddr = '0;  sr_wdata = '0;
                n_st = S_SCAN_I1;
            end
            S_SCAN_I1: begin
                sr_we = 1'b1;  sr_waddr = chgs_pkg::IDX_W'(1);  sr_wdata = chgs_pkg::IDX_W'(1);
                n_depth = chgs_pkg::CNT_W'(2);
                n_i     = chgs_pkg::CNT_W'(2);
                n_st = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                pr_raddr = r_i[chgs_pkg::IDX_W-1:0];
                n_st = S_SCAN_C;
            end
            S_SCAN_C: begin
                n_t = q_pt;
                n_st = S_SCAN_TST;
            end
            S_SCAN_TST: begin
                if (r_depth >= chgs_pkg::CNT_W'(2)) begin
                    sr_raddr = chgs_pkg::IDX_W'(r_depth - chgs_pkg::CNT_W'(2));
                    n_st = S_SCAN_A1;
                end else begin
                    do_push = 1'b1;
                end
            end
            S_SCAN_A1: begin
                pr_raddr = sr_q;
                sr_raddr = chgs_pkg::IDX_W'(r_depth - chgs_pkg::CNT_W'(1));
                n_st = S_SCAN_A2;
            end
            S_SCAN_A2: begin
                n_p = q_pt;
                pr_raddr = sr_q;
                n_st = S_SCAN_B;
            end
            S_SCAN_B: begin
                n_bp = q_pt;
                n_st = S_SCAN_X_GO;
            end
            S_SCAN_X_GO: begin
                alu_req = f_cross(r_p, r_bp, r_t);
                n_st = S_SCAN_X_W;
            end
            S_SCAN_X_W: begin
                if (alu_rsp.done) begin
                    if (alu_zero) n_st = S_SCAN_D_GO;
                    else if (!alu_neg) do_push = 1'b1;
                    else do_pop = 1'b1;
                end
            end
            S_SCAN_D_GO: begin
                alu_req = f_dot(r_p, r_bp, r_t);
                n_st = S_SCAN_D_W;
            end
            S_SCAN_D_W: begin
                if (alu_rsp.done) begin
                    if (!alu_neg && !alu_zero) do_push = 1'b1;
                    else do_pop = 1'b1;
                end
            end
            S_FIN0: begin
                sr_raddr = chgs_pkg::IDX_W'(r_depth - chgs_pkg::CNT_W'(1));
                n_st = S_FIN1;
            end
            S_FIN1: begin
                pr_raddr = sr_q;
                n_st = S_FIN2;
            end
            S_FIN2: begin
                n_q = q_pt;  n_phase = PH_SIDE;  n_cursor = '0;
                n_st = S_IDLE;
            end
            S_SIDE_TST: begin
                if (r_cursor < r_count) begin
                    pr_raddr = r_cursor[chgs_pkg::IDX_W-1:0];
                    n_cursor = r_cursor + chgs_pkg::CNT_W'(1);
                    n_st = S_SIDE_P;
                end else begin
                    n_phase = PH_STACK;  n_cursor = '0;
                    n_st = S_STK_TST;
                end
            end
            S_SIDE_P: begin
                n_p = q_pt;
                n_st = S_SIDE_EQ;
            end
            S_SIDE_EQ: begin
                if (f_same(r_p, r_best) || f_same(r_p, r_q)) n_st = S_SIDE_TST;
                else n_st = S_SIDE_X_GO;
            end
            S_SIDE_X_GO: begin
                alu_req = f_cross(r_best, r_p, r_q);
                n_st = S_SIDE_X_W;
            end
            S_SIDE_X_W: begin
                if (alu_rsp.done) begin
                    if (alu_zero) begin
                        n_rid = chgs_pkg::OID_W'(chgs_pkg::CNT_W'(r_p.id) + chgs_pkg::CNT_W'(1));
                        n_rlast = 1'b0;  n_rempty = 1'b0;
                        n_st = S_EMIT;
                    end else begin
                        n_st = S_SIDE_TST;
                    end
                end
            end
            S_STK_TST: begin
                if (r_cursor < r_depth) begin
                    sr_raddr = r_cursor[chgs_pkg::IDX_W-1:0];
                    n_st = S_STK_A;
                end else begin
                    n_phase = PH_DONE;
                    n_rid = '0;  n_rlast = 1'b0;  n_rempty = 1'b1;
                    n_st = S_EMIT;
                end
            end
            S_STK_A: begin
                pr_raddr = sr_q;
                n_st = S_STK_B;
            end
            S_STK_B: begin
                n_rid = chgs_pkg::OID_W'(chgs_pkg::CNT_W'(q_pt.id) + chgs_pkg::CNT_W'(1));
                n_rempty = 1'b0;
                n_cursor = r_cursor + chgs_pkg::CNT_W'(1);
                n_rlast  = ((r_cursor + chgs_pkg::CNT_W'(1)) >= r_depth);
                if ((r_cursor + chgs_pkg::CNT_W'(1)) >= r_depth) n_phase = PH_DONE;
                n_st = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_oid = r_rid;  n_olast = r_rlast;
                    n_oempty = r_rempty;  n_oovf = r_ovf;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        // insertion sort: drop the held point at j, or move the neighbour up; scan: push or pop
        if (do_place) begin
            pr_we = 1'b1;  pr_waddr = r_j[chgs_pkg::IDX_W-1:0];  pr_wdata = r_t;
            n_i = inc_i;
            n_st = (inc_i < r_count) ? S_INS_RD : S_SCAN_I0;
        end
        if (do_shift) begin
            pr_we = 1'b1;  pr_waddr = r_j[chgs_pkg::IDX_W-1:0];  pr_wdata = r_p;
            n_j = r_j - chgs_pkg::CNT_W'(1);
            n_st = S_INS_CHK;
        end
        if (do_push) begin
            sr_we = 1'b1;  sr_waddr = r_depth[chgs_pkg::IDX_W-1:0];
            sr_wdata = r_i[chgs_pkg::IDX_W-1:0];
            n_depth = r_depth + chgs_pkg::CNT_W'(1);
            n_i = inc_i;
            n_st = (inc_i < r_count) ? S_SCAN_RD : S_FIN0;
        end
        if (do_pop) begin
            n_depth = r_depth - chgs_pkg::CNT_W'(1);
            n_st = S_SCAN_TST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_phase  <= PH_LOAD;
            r_count  <= '0;
            r_depth  <= '0;
            r_cursor <= '0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_depth  <= n_depth;
            r_cursor <= n_cursor;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_j <= n_j;  r_lo <= n_lo;  r_pidx <= n_pidx;
        r_best <= n_best;  r_rec0 <= n_rec0;  r_t <= n_t;  r_p <= n_p;
        r_bp <= n_bp;  r_q <= n_q;  r_di <= n_di;
        r_rid <= n_rid;  r_rlast <= n_rlast;  r_rempty <= n_rempty;
        r_oid <= n_oid;  r_olast <= n_olast;  r_oempty <= n_oempty;  r_oovf <= n_oovf;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = chgs_pkg::OUT_DATA_W'(r_oid);
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = {r_oovf, r_oempty};

    a_depth_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_count) else $error("hull depth exceeds point count");

    a_cursor_in_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STACK) |-> (r_cursor <= r_depth))
        else $error("read cursor beyond hull stack");

    a_last_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> !o_m_axis_tuser[0])
        else $error("last item flagged empty");

    a_plain_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_s_axis_tuser[0] == ACT_LOAD) && !i_s_axis_tlast)
        |=> ((r_phase == PH_LOAD) && o_s_axis_tready))
        else $error("plain load left loading phase");

endmodule

/* bench/convex_hull_graham_scan_tb.sv */
// ============================================================================
// convex_hull_graham_scan_tb
// Checks the convex hull block against a predictor kept in step with the
// stream. Directed point sets come first, then random sets. The sets are
// small grids, wide random clouds, lines with repeated points, and one
// convex arc that overflows the point store. Both sides idle at random.
// ============================================================================
module convex_hull_graham_scan_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {PH_LOADING, PH_SIDE_IDS, PH_HULL_IDS, PH_ENDED} t_rd_phase;

    typedef struct {
        bit                              pause;
        bit                              rd;
        logic [chgs_pkg::COORD_BITS-1:0] x;
        logic [chgs_pkg::COORD_BITS-1:0] y;
        bit                              fin;
    } t_item;

    typedef struct {
        logic [chgs_pkg::OUT_DATA_W-1:0] data;
        bit                              last;
        bit                              empty;
        bit                              ovf;
    } t_hull_id;

    localparam int LO_C = -(1 << (chgs_pkg::COORD_BITS - 1));
    localparam int HI_C = (1 << (chgs_pkg::COORD_BITS - 1)) - 1;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [chgs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            i_s_axis_tlast = 1'b0;
    logic [0:0]                      i_s_axis_tuser = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [chgs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tlast;
    logic [1:0]                      o_m_axis_tuser;

    convex_hull_graham_scan u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint    pt_x [chgs_pkg::MAX_POINTS];
    longint    pt_y [chgs_pkg::MAX_POINTS];
    int        pt_id [chgs_pkg::MAX_POINTS];
    int        stk [chgs_pkg::MAX_POINTS];
    int        n_pts, stk_depth, cursor;
    t_rd_phase rd_phase;
    bit        ovf_seen;

    t_item    pending [$];
    t_hull_id hull_ids_due [$];
    int       n_errors, n_results;

    function automatic longint cross3(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic bit angle_before(longint ix, longint iy, longint jx, longint jy);
        longint c, di, dj;
        if (jx == pt_x[0] && jy == pt_y[0]) return 1'b0;
        if (ix == pt_x[0] && iy == pt_y[0]) return 1'b1;
        c = cross3(pt_x[0], pt_y[0], ix, iy, jx, jy);
        if (c != 0) return c > 0;
        di = (ix - pt_x[0]) * (ix - pt_x[0]) + (iy - pt_y[0]) * (iy - pt_y[0]);
        dj = (jx - pt_x[0]) * (jx - pt_x[0]) + (jy - pt_y[0]) * (jy - pt_y[0]);
        return di < dj;
    endfunction

    function automatic bit left_turn(int a, int b, int c);
        longint ar, d;
        ar = cross3(pt_x[a], pt_y[a], pt_x[b], pt_y[b], pt_x[c], pt_y[c]);
        if (ar != 0) return ar > 0;
        d = (pt_x[b] - pt_x[a]) * (pt_x[c] - pt_x[b])
          + (pt_y[b] - pt_y[a]) * (pt_y[c] - pt_y[b]);
        return d > 0;
    endfunction

    function automatic int lowest_point();
        int lo;
        lo = 0;
        for (int i = 1; i < n_pts; i++)
            if (pt_y[i] < pt_y[lo] || (pt_y[i] == pt_y[lo] && pt_x[i] < pt_x[lo])) lo = i;
        return lo;
    endfunction

    task automatic build_hull();
        int lo, j, tid;
        longint tx, ty;
        cursor = 0;
        lo = lowest_point();
        if (n_pts < 3) begin
            for (int i = 0; i < n_pts; i++) stk[i] = i;
            if (lo != 0) begin
                stk[0] = lo;
                stk[lo] = 0;
            end
            stk_depth = n_pts;
            rd_phase = (n_pts != 0) ? PH_HULL_IDS : PH_ENDED;
            return;
        end
        tx = pt_x[0]; ty = pt_y[0]; tid = pt_id[0];
        pt_x[0] = pt_x[lo]; pt_y[0] = pt_y[lo]; pt_id[0] = pt_id[lo];
        pt_x[lo] = tx; pt_y[lo] = ty; pt_id[lo] = tid;
        for (int i = 2; i < n_pts; i++) begin
            tx = pt_x[i]; ty = pt_y[i]; tid = pt_id[i];
            j = i;
            while (j > 1 && angle_before(tx, ty, pt_x[j-1], pt_y[j-1])) begin
                pt_x[j] = pt_x[j-1]; pt_y[j] = pt_y[j-1]; pt_id[j] = pt_id[j-1];
                j--;
            end
            pt_x[j] = tx; pt_y[j] = ty; pt_id[j] = tid;
        end
        stk[0] = 0;
        stk[1] = 1;
        stk_depth = 2;
        for (int i = 2; i < n_pts; i++) begin
            while (stk_depth >= 2 && !left_turn(stk[stk_depth-2], stk[stk_depth-1], i))
                stk_depth--;
            stk[stk_depth] = i;
            stk_depth++;
        end
        rd_phase = PH_SIDE_IDS;
    endtask

    task automatic apply_item(t_item it);
        int id, t, k;
        bit last;
        longint qx, qy;
        t_hull_id r;
        id = 0;
        last = 0;
        if (!it.rd) begin
            if (rd_phase != PH_LOADING) begin
                n_pts = 0; stk_depth = 0; cursor = 0; ovf_seen = 0;
                rd_phase = PH_LOADING;
            end
            if (n_pts < chgs_pkg::MAX_POINTS) begin
                pt_x[n_pts] = longint'($signed(it.x));
                pt_y[n_pts] = longint'($signed(it.y));
                pt_id[n_pts] = n_pts;
                n_pts++;
            end else begin
                ovf_seen = 1;
            end
            if (it.fin) build_hull();
            return;
        end
        if (rd_phase == PH_SIDE_IDS) begin
            t = stk[stk_depth-1];
            qx = pt_x[t];
            qy = pt_y[t];
            while (cursor < n_pts && id == 0) begin
                k = cursor;
                cursor++;
                if ((pt_x[k] == pt_x[0] && pt_y[k] == pt_y[0]) ||
                    (pt_x[k] == qx && pt_y[k] == qy))
                    continue;
                if (cross3(pt_x[0], pt_y[0], pt_x[k], pt_y[k], qx, qy) == 0) id = pt_id[k] + 1;
            end
            if (id == 0) begin
                rd_phase = PH_HULL_IDS;
                cursor = 0;
            end
        end
        if (id == 0 && rd_phase == PH_HULL_IDS) begin
            if (cursor < stk_depth) begin
                id = pt_id[stk[cursor]] + 1;
                cursor++;
                if (cursor >= stk_depth) begin
                    last = 1;
                    rd_phase = PH_ENDED;
                end
            end else begin
                rd_phase = PH_ENDED;
            end
        end
        r.data = chgs_pkg::OUT_DATA_W'(id & 'h7FF);
        r.last = last;
        r.empty = (id == 0);
        r.ovf = ovf_seen;
        hull_ids_due.push_back(r);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int    in_gap;
    t_item cur;
    always @(posedge i_clk) begin
        bit v;
        v = i_s_axis_tvalid;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_item(cur);
                v = 0;
                in_gap = gap_len();
            end
            if (!v) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending.size() > 0) begin
                    if (pending[0].pause) begin
                        if (hull_ids_due.size() == 0) void'(pending.pop_front());
                    end else begin
                        cur = pending.pop_front();
                        v = 1;
                        i_s_axis_tdata <= {2'b00, cur.y, cur.x};
                        i_s_axis_tlast <= cur.fin;
                        i_s_axis_tuser <= cur.rd;
                    end
                end
            end
            i_s_axis_tvalid <= v;
        end
    end

    // monitor
    int hold_cnt;
    bit held_once;
    always @(posedge i_clk) begin
        t_hull_id e;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results++;
                if (hull_ids_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected item id=%0d", o_m_axis_tdata);
                end else begin
                    e = hull_ids_due.pop_front();
                    if (o_m_axis_tdata !== e.data || o_m_axis_tlast !== e.last ||
                        o_m_axis_tuser[0] !== e.empty || o_m_axis_tuser[1] !== e.ovf) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch: exp id=%0d last=%0d empty=%0d ovf=%0d,",
                                      " got id=%0d last=%0d empty=%0d ovf=%0d"},
                                     e.data, e.last, e.empty, e.ovf, o_m_axis_tdata,
                                     o_m_axis_tlast, o_m_axis_tuser[0], o_m_axis_tuser[1]);
                    end
                end
            end
            if (!held_once && n_results == 150) begin
                held_once <= 1;
                hold_cnt <= 400;
                i_m_axis_tready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_m_axis_tready <= (hold_cnt == 1);
            end else begin
                i_m_axis_tready <= (gap_len() == 0);
            end
        end
    end

    task automatic add_load(int x, int y, bit fin);
        t_item it;
        it.pause = 0; it.rd = 0; it.fin = fin;
        it.x = x[chgs_pkg::COORD_BITS-1:0];
        it.y = y[chgs_pkg::COORD_BITS-1:0];
        pending.push_back(it);
    endtask

    task automatic add_reads(int k);
        t_item it;
        for (int i = 0; i < k; i++) begin
            it.pause = 0; it.rd = 1; it.fin = 1'($urandom_range(0, 1));
            it.x = chgs_pkg::COORD_BITS'($urandom());
            it.y = chgs_pkg::COORD_BITS'($urandom());
            pending.push_back(it);
        end
    endtask

    task automatic add_pause();
        t_item it;
        it.pause = 1; it.rd = 0; it.fin = 0; it.x = '0; it.y = '0;
        pending.push_back(it);
    endtask

    // kind 0 small grid, 1 wide random, 2 line with repeats
    task automatic add_set(int kind, int n);
        int x, y, dx, dy;
        dx = $urandom_range(0, 4) - 2;
        dy = $urandom_range(0, 4) - 2;
        for (int i = 0; i < n; i++) begin
            unique case (kind)
                0: begin
                    x = $urandom_range(0, 8) - 4;
                    y = $urandom_range(0, 8) - 4;
                end
                1: begin
                    x = $signed(chgs_pkg::COORD_BITS'($urandom()));
                    y = $signed(chgs_pkg::COORD_BITS'($urandom()));
                end
                default: begin
                    x = dx * $urandom_range(0, 5);
                    y = dy * (x / (dx == 0 ? 1 : dx));
                    if (dx == 0) y = dy * $urandom_range(0, 5);
                end
            endcase
            add_load(x, y, i == n - 1);
        end
    endtask

    initial begin
        int sz;
        // read while loading, single and two points
        add_reads(2);
        add_load(5, 5, 1);
        add_reads(3);
        add_load(3, 1, 0);
        add_load(-2, 1, 1);
        add_reads(3);
        // extremes with a duplicate of the anchor and edge points
        add_load(HI_C, HI_C, 0);
        add_load(LO_C, LO_C, 0);
        add_load(HI_C, LO_C, 0);
        add_load(LO_C, LO_C, 0);
        add_load(0, LO_C, 0);
        add_load(LO_C, HI_C, 0);
        add_load(LO_C, 0, 1);
        add_reads(10);
        add_pause();
        // load after a partly read list
        add_set(0, 6);
        add_reads(2);
        add_set(2, 5);
        add_reads(8);
        // convex arc past the store size; the dropped last load starts it
        for (int k = 0; k < chgs_pkg::MAX_POINTS + 6; k++)
            add_load(k, k * k, k == chgs_pkg::MAX_POINTS + 5);
        add_reads(30);
        add_pause();
        while (pending.size() < 1700) begin
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 12);
            add_set($urandom_range(0, 5) == 0 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0), sz);
            add_reads($urandom_range(0, 4) == 0 ? $urandom_range(0, sz) : sz + 3);
            if ($urandom_range(0, 30) == 0) add_pause();
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending.size() == 0);
        @(posedge i_clk);
        wait (!i_s_axis_tvalid);
        wait (hull_ids_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0 && hull_ids_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
rtl/chgs_pkg.sv
rtl/chgs_ram.sv
rtl/chgs_alu.sv
rtl/convex_hull_graham_scan.sv
bench/convex_hull_graham_scan_tb.sv
